// ===== hdl/mfm_sd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM sector deframer package
// Shared types, constants and CRC / bit extraction helpers.
// ----------------------------------------------------------------------------
package mfm_sd_pkg;

	localparam int MAX_SECTORS_DEF = 32;

	localparam logic [15:0] SYNC_RAW = 16'h4489;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_SEED = 16'hCDB4;

	localparam logic [7:0] MARK_ID       = 8'hFE;
	localparam logic [7:0] MARK_DATA     = 8'hFB;
	localparam logic [7:0] MARK_DATA_ALT = 8'hFA;
	localparam logic [7:0] MARK_DEL      = 8'hF8;
	localparam logic [7:0] MARK_DEL_ALT  = 8'hF9;

	localparam logic [15:0] SIZE_CAP = 16'h8000;
	localparam logic [15:0] SIZE_MIN = 16'd128;
	localparam logic [2:0]  SIZE_MAX_CODE = 3'd7;

	localparam logic [7:0] GAP_MIN_RST = 8'd32;
	localparam logic [7:0] GAP_MAX_RST = 8'd63;
	localparam logic [7:0] GAP_SAT = 8'hFF;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_DATA_W = 48;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_SYNC2  = 3'd1,
		PH_SYNC3  = 3'd2,
		PH_MARK   = 3'd3,
		PH_ID     = 3'd4,
		PH_DATA   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ID      = 2'd0,
		KIND_DATA    = 2'd1,
		KIND_END     = 2'd2,
		KIND_OUTSIDE = 2'd3
	} kind_t;

	// For KIND_ID the info word holds C, H, R, N from the lowest byte up.
	// For KIND_DATA its lowest byte is the data byte.
	typedef struct packed {
		kind_t       kind;
		logic [4:0]  slot;
		logic [31:0] info;
		logic        deleted;
		logic        crc_error;
	} item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] data_bits(input logic [15:0] w);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = w[2 * i];
		end
		return r;
	endfunction

endpackage

// ===== hdl/mfm_sd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM sector deframer front end
// Takes one cell per transaction, finds sync words, reads marks, ID and data
// fields, checks the CRC and hands finished items to the queue.
// ----------------------------------------------------------------------------
module mfm_sd_front #(
	parameter int MAX_SECTORS = mfm_sd_pkg::MAX_SECTORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mfm_sd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                       cfg_wdata,
	input  logic                             cell_valid,
	input  logic                             raw_cell,
	input  logic                             track_start,
	input  logic                             queue_ready,
	output logic                             push,
	output mfm_sd_pkg::item_t                item
);
	import mfm_sd_pkg::*;

	localparam int SC_W = $clog2(MAX_SECTORS + 1);

	logic [7:0]      min_gap_q, max_gap_q;
	logic [15:0]     win_q, win_b, win_n;
	phase_t          phase_q, phase_b, phase_n;
	logic [3:0]      cc_q, cc_b, cc_n, cc_inc;
	logic [15:0]     bc_q, bc_b, bc_n;
	logic [15:0]     crc_q, crc_n, crc_b;
	logic [3:0][7:0] hdr_q, hdr_n;
	logic            pend_q, pend_b, pend_n;
	logic [7:0]      gap_q, gap_b, gap_n;
	logic [3:0]      gapc_q, gapc_b, gapc_n;
	logic [SC_W-1:0] sc_q, sc_b, sc_n;
	logic            del_q, del_n;
	logic [7:0]      byte_v;
	logic [15:0]     size_v;
	logic            accept;
	logic            res_v;
	item_t           res;

	assign accept = cell_valid && queue_ready;
	assign push = accept && res_v;
	assign item = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= GAP_MIN_RST;
			max_gap_q <= GAP_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_GAP: min_gap_q <= cfg_wdata;
				CFG_MAX_GAP: max_gap_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			phase_q <= PH_SEARCH;
			cc_q    <= '0;
			bc_q    <= '0;
			crc_q   <= CRC_SEED;
			hdr_q   <= '0;
			pend_q  <= 1'b0;
			gap_q   <= '0;
			gapc_q  <= '0;
			sc_q    <= '0;
			del_q   <= 1'b0;
		end else if (accept) begin
			win_q   <= win_n;
			phase_q <= phase_n;
			cc_q    <= cc_n;
			bc_q    <= bc_n;
			crc_q   <= crc_n;
			hdr_q   <= hdr_n;
			pend_q  <= pend_n;
			gap_q   <= gap_n;
			gapc_q  <= gapc_n;
			sc_q    <= sc_n;
			del_q   <= del_n;
		end
	end

	always_comb begin
		win_b   = track_start ? '0 : win_q;
		phase_b = track_start ? PH_SEARCH : phase_q;
		cc_b    = track_start ? '0 : cc_q;
		bc_b    = track_start ? '0 : bc_q;
		pend_b  = track_start ? 1'b0 : pend_q;
		gap_b   = track_start ? '0 : gap_q;
		gapc_b  = track_start ? '0 : gapc_q;
		sc_b    = track_start ? '0 : sc_q;

		win_n   = {win_b[14:0], raw_cell};
		phase_n = phase_b;
		cc_n    = cc_b;
		bc_n    = bc_b;
		crc_n   = crc_q;
		hdr_n   = hdr_q;
		pend_n  = pend_b;
		gap_n   = gap_b;
		gapc_n  = gapc_b;
		sc_n    = sc_b;
		del_n   = del_q;
		res_v   = 1'b0;
		res     = '0;

		byte_v = data_bits(win_n);
		crc_b  = crc_byte(crc_q, byte_v);
		size_v = (hdr_q[3] <= {5'd0, SIZE_MAX_CODE}) ? (SIZE_MIN << hdr_q[3][2:0]) : SIZE_CAP;
		cc_inc = cc_b + 4'd1;

		if (pend_b) begin
			gapc_n = gapc_b + 4'd1;
			if (gapc_n == 4'd0 && gap_b != GAP_SAT) begin
				gap_n = gap_b + 8'd1;
			end
		end

		if (phase_b inside {PH_SYNC2, PH_SYNC3, PH_MARK, PH_ID, PH_DATA}) begin
			cc_n = cc_inc;
			if (cc_inc == 4'd0) begin
				case (phase_b)
					PH_SYNC2: begin
						phase_n = (win_n == SYNC_RAW) ? PH_SYNC3 : PH_SEARCH;
					end
					PH_SYNC3: begin
						if (win_n == SYNC_RAW) begin
							phase_n = PH_MARK;
							crc_n = CRC_SEED;
						end else begin
							phase_n = PH_SEARCH;
						end
					end
					PH_MARK: begin
						crc_n = crc_b;
						phase_n = PH_SEARCH;
						if (byte_v == MARK_ID) begin
							if (sc_b < SC_W'(MAX_SECTORS)) begin
								pend_n = 1'b0;
								bc_n = '0;
								phase_n = PH_ID;
							end
						end else if (byte_v inside {MARK_DATA, MARK_DATA_ALT, MARK_DEL,
								MARK_DEL_ALT}) begin
							if (pend_b) begin
								pend_n = 1'b0;
								if (gap_n < min_gap_q || gap_n > max_gap_q) begin
									res_v = 1'b1;
									res.kind = KIND_OUTSIDE;
									res.slot = 5'({5'd0, sc_b} - 1'b1);
									res.deleted = byte_v inside {MARK_DEL, MARK_DEL_ALT};
								end else begin
									del_n = byte_v inside {MARK_DEL, MARK_DEL_ALT};
									bc_n = '0;
									phase_n = PH_DATA;
								end
							end
						end
					end
					PH_ID: begin
						crc_n = crc_b;
						if (bc_b < 16'd4) begin
							hdr_n[bc_b[1:0]] = byte_v;
						end
						bc_n = bc_b + 16'd1;
						if (bc_n >= 16'd6) begin
							phase_n = PH_SEARCH;
							if (crc_b == 16'd0) begin
								pend_n = 1'b1;
								gap_n = '0;
								gapc_n = '0;
								sc_n = sc_b + 1'b1;
								res_v = 1'b1;
								res.kind = KIND_ID;
								res.slot = 5'({5'd0, sc_b});
								res.info = hdr_n;
							end
						end
					end
					PH_DATA: begin
						crc_n = crc_b;
						bc_n = bc_b + 16'd1;
						if (bc_b < size_v) begin
							res_v = 1'b1;
							res.kind = KIND_DATA;
							res.slot = 5'({5'd0, sc_b} - 1'b1);
							res.info = {24'd0, byte_v};
							res.deleted = del_q;
						end else if ({1'b0, bc_n} >= {1'b0, size_v} + 17'd2) begin
							phase_n = PH_SEARCH;
							res_v = 1'b1;
							res.kind = KIND_END;
							res.slot = 5'({5'd0, sc_b} - 1'b1);
							res.deleted = del_q;
							res.crc_error = (crc_b != 16'd0);
						end
					end
					default: phase_n = PH_SEARCH;
				endcase
			end
		end else begin
			phase_n = PH_SEARCH;
			if (cc_b != 4'hF) begin
				cc_n = cc_inc;
			end else if (win_n == SYNC_RAW) begin
				phase_n = PH_SYNC2;
				cc_n = '0;
			end
		end
	end

	a_push_ready: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> queue_ready)
		else $error("item pushed into a full queue");
	a_sector_limit: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= SC_W'(MAX_SECTORS))
		else $error("sector count beyond limit");
	a_id_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push && item.kind == KIND_ID |=> sc_q == SC_W'($past(sc_q) + 1'b1))
		else $error("accepted ID did not advance the sector count");

endmodule

// ===== hdl/mfm_sd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM sector deframer item queue
// Short queue between the front end and the output stage.
// ----------------------------------------------------------------------------
module mfm_sd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mfm_sd_pkg::item_t push_item,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output mfm_sd_pkg::item_t head
);
	import mfm_sd_pkg::*;

	item_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;

	assign full = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QUEUE_CW'(push) - QUEUE_CW'(pop);
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== hdl/mfm_sd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM sector deframer output stage
// Keeps the last accepted header and registers one result transaction.
// ----------------------------------------------------------------------------
module mfm_sd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  mfm_sd_pkg::item_t                   item,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mfm_sd_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [1:0]                          m_tuser
);
	import mfm_sd_pkg::*;

	logic [31:0] hdr_q;
	logic [31:0] hdr_v;
	logic [7:0]  byte_v;

	assign pop = item_valid && (!m_tvalid || m_tready);
	assign hdr_v = (item.kind == KIND_ID) ? item.info : hdr_q;
	assign byte_v = (item.kind == KIND_DATA) ? item.info[7:0] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (pop) begin
				hdr_q <= hdr_v;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= {1'b0, item.crc_error, item.deleted, byte_v, hdr_v, item.slot};
			m_tuser <= item.kind;
		end
	end

endmodule

// ===== hdl/mfm_sector_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM sector deframer
// Decodes ID and data fields of MFM floppy sectors from a raw cell stream.
// ----------------------------------------------------------------------------
// The input stream carries one MFM cell per transaction, with track_start in
// s_tuser marking the first cell of a track. Each accepted ID field, each data
// byte, each data field end and each data mark outside the gap window gives
// one transaction on the output stream, with its kind in m_tuser.
// The gap window limits are written through the cfg port; the user must do so
// only while idle, as the block itself does not enforce it. One cell is taken
// every cycle while the queue has room. The front end decodes a cell in the
// cycle it is accepted and the queue stores the result at that edge; the output
// register then takes it from the queue once the output is free, raising m_tvalid.
// The front end does all work on a cell combinationally, registering its state;
// the CRC advances a whole byte at each 16-cell word boundary.
// Reset clears the search state, the sector count and the gap limits back to
// 32 and 63 words.
// When the receiver stalls, results wait in a two-entry queue and the output
// register; once the queue is full, s_tready drops until it frees an entry.
// ----------------------------------------------------------------------------
module mfm_sector_deframer #(
	parameter int MAX_SECTORS = mfm_sd_pkg::MAX_SECTORS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mfm_sd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // raw_cell, zero fill
	input  logic                              s_tuser,  // track_start
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sector_index[4:0], cylinder, side, record, size_code, data_byte,
	// deleted, crc_error, zero fill
	output logic [mfm_sd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                        m_tuser   // kind
);
	import mfm_sd_pkg::*;

	logic  push, pop, full, not_empty;
	item_t push_item, head;

	assign s_tready = !full;

	mfm_sd_front #(
		.MAX_SECTORS(MAX_SECTORS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.cell_valid (s_tvalid),
		.raw_cell   (s_tdata[0]),
		.track_start(s_tuser),
		.queue_ready(s_tready),
		.push       (push),
		.item       (push_item)
	);

	mfm_sd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.full     (full),
		.not_empty(not_empty),
		.head     (head)
	);

	mfm_sd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(not_empty),
		.item      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ===== sim/tb_mfm_sector_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM sector deframer testbench
// Drives MFM-encoded tracks into the deframer one cell per transaction and
// checks every output transaction against a cycle-free model of the decoder.
// ----------------------------------------------------------------------------
// The stimulus is a short track under a narrow gap window: noise, an ID field
// followed by a data field that a track start cuts after a few bytes, an ID
// field whose data mark lands one word past the window, a data mark with no
// header and a stretch of noise. The first sector runs with no idling.
// ----------------------------------------------------------------------------
module tb_mfm_sector_deframer;

	import mfm_sd_pkg::*;

	typedef struct packed {
		logic raw;
		logic track_start;
	} cell_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [4:0] slot;
		logic [7:0] cyl;
		logic [7:0] head;
		logic [7:0] rec;
		logic [7:0] ncode;
		logic [7:0] dbyte;
		logic       del;
		logic       crc_bad;
	} sector_item_t;

	typedef logic [7:0] byte_q_t[$];

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_GAP;
	logic [7:0]            cfg_wdata = 8'd0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'd0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	mfm_sector_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	cell_item_t   cell_q[$];
	sector_item_t sector_exp[$];
	int           mismatch_count = 0;
	logic         no_idle = 1'b0;
	logic         prev_bit = 1'b0;
	logic         ts_next = 1'b0;

	// Decoder model state.
	logic [15:0] win = 16'd0;
	phase_t      ph = PH_SEARCH;
	logic [3:0]  cell_cnt = 4'd0;
	logic [15:0] byte_cnt = 16'd0;
	logic [15:0] crc_acc = CRC_SEED;
	logic [7:0]  hdr[4] = '{8'd0, 8'd0, 8'd0, 8'd0};
	logic        hdr_open = 1'b0;
	logic [7:0]  gap_wd = 8'd0;
	logic [3:0]  gap_cell = 4'd0;
	logic [5:0]  sect_cnt = 6'd0;
	logic        del_mark = 1'b0;
	logic [7:0]  win_lo = GAP_MIN_RST;
	logic [7:0]  win_hi = GAP_MAX_RST;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int unsigned field_len(input logic [7:0] n);
		return (n <= 8'd7) ? (32'd128 << n) : 32'd32768;
	endfunction

	function automatic sector_item_t make_item(input kind_t k, input logic [4:0] s,
			input logic [7:0] d, input logic dl, input logic ce);
		sector_item_t t;
		t.kind = k;
		t.slot = s;
		t.cyl = hdr[0];
		t.head = hdr[1];
		t.rec = hdr[2];
		t.ncode = hdr[3];
		t.dbyte = d;
		t.del = dl;
		t.crc_bad = ce;
		return t;
	endfunction

	function automatic void deframe_cell(input logic raw, input logic ts, output logic got,
			output sector_item_t r);
		logic [5:0]  prev_cnt;
		logic [4:0]  slot;
		logic [7:0]  b;
		logic        dl;
		int unsigned size;
		got = 1'b0;
		r = '0;
		prev_cnt = sect_cnt - 6'd1;
		slot = prev_cnt[4:0];
		if (ts) begin
			win = 16'd0;
			ph = PH_SEARCH;
			cell_cnt = 4'd0;
			byte_cnt = 16'd0;
			hdr_open = 1'b0;
			gap_wd = 8'd0;
			gap_cell = 4'd0;
			sect_cnt = 6'd0;
			slot = 5'h1F;
		end
		win = {win[14:0], raw};
		if (hdr_open) begin
			gap_cell = gap_cell + 4'd1;
			if (gap_cell == 4'd0 && gap_wd != GAP_SAT) begin
				gap_wd = gap_wd + 8'd1;
			end
		end
		if (ph == PH_SEARCH) begin
			if (cell_cnt < 4'd15) begin
				cell_cnt = cell_cnt + 4'd1;
			end else if (win == SYNC_RAW) begin
				ph = PH_SYNC2;
				cell_cnt = 4'd0;
			end
			return;
		end
		cell_cnt = cell_cnt + 4'd1;
		if (cell_cnt != 4'd0) begin
			return;
		end
		for (int i = 0; i < 8; i++) begin
			b[i] = win[2 * i];
		end
		case (ph)
			PH_SYNC2: begin
				ph = (win == SYNC_RAW) ? PH_SYNC3 : PH_SEARCH;
			end
			PH_SYNC3: begin
				if (win == SYNC_RAW) begin
					ph = PH_MARK;
					crc_acc = CRC_SEED;
				end else begin
					ph = PH_SEARCH;
				end
			end
			PH_MARK: begin
				crc_acc = crc16_step(crc_acc, b);
				ph = PH_SEARCH;
				if (b == MARK_ID) begin
					if (sect_cnt < MAX_SECTORS_DEF) begin
						hdr_open = 1'b0;
						byte_cnt = 16'd0;
						ph = PH_ID;
					end
				end else if (b == MARK_DATA || b == MARK_DATA_ALT || b == MARK_DEL ||
						b == MARK_DEL_ALT) begin
					dl = (b == MARK_DEL || b == MARK_DEL_ALT);
					if (hdr_open) begin
						hdr_open = 1'b0;
						if (gap_wd < win_lo || gap_wd > win_hi) begin
							got = 1'b1;
							r = make_item(KIND_OUTSIDE, slot, 8'd0, dl, 1'b0);
						end else begin
							del_mark = dl;
							byte_cnt = 16'd0;
							ph = PH_DATA;
						end
					end
				end
			end
			PH_ID: begin
				crc_acc = crc16_step(crc_acc, b);
				if (byte_cnt < 16'd4) begin
					hdr[byte_cnt[1:0]] = b;
				end
				byte_cnt = byte_cnt + 16'd1;
				if (byte_cnt >= 16'd6) begin
					ph = PH_SEARCH;
					if (crc_acc == 16'd0) begin
						hdr_open = 1'b1;
						gap_wd = 8'd0;
						gap_cell = 4'd0;
						got = 1'b1;
						r = make_item(KIND_ID, sect_cnt[4:0], 8'd0, 1'b0, 1'b0);
						sect_cnt = sect_cnt + 6'd1;
					end
				end
			end
			default: begin
				size = field_len(hdr[3]);
				crc_acc = crc16_step(crc_acc, b);
				if (byte_cnt < size) begin
					byte_cnt = byte_cnt + 16'd1;
					got = 1'b1;
					r = make_item(KIND_DATA, slot, b, del_mark, 1'b0);
				end else begin
					byte_cnt = byte_cnt + 16'd1;
					if (byte_cnt >= size + 2) begin
						ph = PH_SEARCH;
						got = 1'b1;
						r = make_item(KIND_END, slot, 8'd0, del_mark, crc_acc != 16'd0);
					end
				end
			end
		endcase
	endfunction

	function automatic void push_cell(input logic c);
		cell_q.push_back(cell_item_t'{raw: c, track_start: ts_next});
		ts_next = 1'b0;
	endfunction

	function automatic void push_word(input logic [15:0] w);
		for (int i = 15; i >= 0; i--) begin
			push_cell(w[i]);
		end
		prev_bit = w[0];
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--) begin
			push_cell(~(prev_bit | b[i]));
			push_cell(b[i]);
			prev_bit = b[i];
		end
	endfunction

	function automatic void push_fill(input int n);
		for (int i = 0; i < n; i++) begin
			push_byte(8'h4E);
		end
	endfunction

	function automatic void push_noise(input int n);
		logic c;
		for (int i = 0; i < n; i++) begin
			c = $urandom_range(1);
			push_cell(c);
			prev_bit = c;
		end
	endfunction

	function automatic byte_q_t random_body(input int len);
		byte_q_t q;
		for (int i = 0; i < len; i++) begin
			q.push_back($urandom);
		end
		return q;
	endfunction

	function automatic byte_q_t id_body(input logic [7:0] c, input logic [7:0] h,
			input logic [7:0] r, input logic [7:0] n);
		byte_q_t q;
		q.push_back(c);
		q.push_back(h);
		q.push_back(r);
		q.push_back(n);
		return q;
	endfunction

	// A nonnegative cut_at raises track_start on the cell after the bytes that precede it.
	function automatic void push_field(input logic [7:0] mark, input byte_q_t body,
			input logic bad_crc, input int cut_at);
		logic [15:0] crc;
		repeat (3) push_word(SYNC_RAW);
		push_byte(mark);
		crc = crc16_step(CRC_SEED, mark);
		foreach (body[i]) begin
			if (i == cut_at) begin
				ts_next = 1'b1;
				return;
			end
			push_byte(body[i]);
			crc = crc16_step(crc, body[i]);
		end
		if (bad_crc) begin
			crc = crc ^ $urandom_range(1, 65535);
		end
		push_byte(crc[15:8]);
		push_byte(crc[7:0]);
	endfunction

	// The data mark word ends gw words after the end of the ID CRC's last word.
	function automatic void push_sector(input logic [7:0] c, input logic [7:0] h,
			input logic [7:0] r, input logic [7:0] n, input int gw, input logic [7:0] mark,
			input logic bad_id, input logic bad_data, input int cut_at);
		push_fill(3);
		push_field(MARK_ID, id_body(c, h, r, n), bad_id, -1);
		push_fill(gw - 4);
		push_field(mark, random_body(field_len(n)), bad_data, cut_at);
		push_fill(2);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic drain();
		while (cell_q.size() != 0 || s_tvalid || sector_exp.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_gap_window(input logic [7:0] lo, input logic [7:0] hi);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_GAP;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= CFG_MAX_GAP;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_lo = lo;
		win_hi = hi;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (cell_q.size() != 0 && (no_idle || $urandom_range(99) >= 7)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, cell_q[0].raw};
				s_tuser <= cell_q[0].track_start;
				void'(cell_q.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic         produced;
		sector_item_t fresh;
		sector_item_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 7);
			if (s_tvalid && s_tready) begin
				deframe_cell(s_tdata[0], s_tuser, produced, fresh);
				if (produced) begin
					sector_exp.push_back(fresh);
				end
			end
			if (m_tvalid && m_tready) begin
				if (sector_exp.size() == 0) begin
					$error("output transaction with nothing expected, kind %0d", m_tuser);
					mismatch_count++;
				end else begin
					want = sector_exp.pop_front();
					check_field("kind", want.kind, m_tuser);
					check_field("sector_index", want.slot, m_tdata[4:0]);
					check_field("cylinder", want.cyl, m_tdata[12:5]);
					check_field("side", want.head, m_tdata[20:13]);
					check_field("record", want.rec, m_tdata[28:21]);
					check_field("size_code", want.ncode, m_tdata[36:29]);
					check_field("data_byte", want.dbyte, m_tdata[44:37]);
					check_field("deleted", want.del, m_tdata[45]);
					check_field("crc_error", want.crc_bad, m_tdata[46]);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A window of 0 to 5 words lets a short track reach the data field.
		write_gap_window(8'd0, 8'd5);

		// Header and the first data bytes, then a track start cuts the field.
		no_idle = 1'b1;
		ts_next = 1'b1;
		push_noise(24);
		push_sector(8'h12, 8'h01, 8'h05, 8'h00, 4, MARK_DATA, 1'b0, 1'b0, 3);
		drain();
		no_idle = 1'b0;

		// A deleted data mark one word past the window, then one with no header.
		push_sector(8'h13, 8'h00, 8'h06, 8'h01, 6, MARK_DEL, 1'b0, 1'b0, 0);
		push_field(MARK_DATA_ALT, random_body(0), 1'b0, -1);
		push_noise(40);
		drain();

		if (mismatch_count == 0 && sector_exp.size() == 0) begin
			$display("tb_mfm_sector_deframer: clean");
		end else begin
			$display("tb_mfm_sector_deframer: errors");
		end
		$finish;
	end

	initial begin
		#200_000;
		$display("tb_mfm_sector_deframer: errors");
		$finish;
	end

endmodule
